// ----- sv/frd_pkg.sv -----
// ----------------------------------------------------------------------------
// frd_pkg
// Shared constants and types of the focuser reply deframer: frame codes,
// status codes and the result record handed from the parser to the output.
// ----------------------------------------------------------------------------
package frd_pkg;

	// frame framing constants
	localparam logic [7:0] START_BYTE = 8'h3b;
	localparam int HDR_BYTES = 3;

	// default data capacity and number of stored data byte slots
	localparam int MAX_DATA_BYTES_DEF = 4;
	localparam int DATA_SLOTS = 4;

	// field widths
	localparam int ADDR_W = 8;
	localparam int CNT_W = 3;
	localparam int DATA_W = 8 * DATA_SLOTS;
	localparam int TDATA_W = 64;

	// frame status codes
	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_CSUM = 2'd1,
		ST_LEN  = 2'd2
	} frame_status_t;

	// one decoded frame
	typedef struct packed {
		logic [ADDR_W-1:0] source_addr;
		logic [ADDR_W-1:0] dest_addr;
		logic [ADDR_W-1:0] command_code;
		logic [CNT_W-1:0]  data_count;
		logic [DATA_W-1:0] data_word;
		frame_status_t     frame_status;
	} frame_res_t;

endpackage

// ----- sv/focuser_reply_deframer.sv -----
// ----------------------------------------------------------------------------
// focuser_reply_deframer
// Deframes replies of a byte-oriented serial link into one record per frame.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle on the slave port, with no gaps needed.
// A frame is start byte 0x3b, count byte N (source, destination, command and
// data bytes), the N bytes and a two's complement checksum. Each frame gives
// one item on the master port, registered from the byte that ends it: the
// checksum byte, or the count byte when N is out of range (status bad length,
// all other fields zero). Results pass through an output register and a
// one-entry skid stage, so s_tready drops only when both hold an item that
// the master side has not yet taken.
module focuser_reply_deframer #(
	parameter int MAX_DATA_BYTES = frd_pkg::MAX_DATA_BYTES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [7:0]                  s_tdata,   // rx_byte
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// source_addr[7:0], dest_addr[15:8], command_code[23:16],
	// data_count[26:24], data_word[58:27], zero fill[63:59]
	output logic [frd_pkg::TDATA_W-1:0] m_tdata,
	output logic [1:0]                  m_tuser    // frame_status
);
	import frd_pkg::*;

	localparam int PackW = 3 * ADDR_W + CNT_W + DATA_W;

	logic       s_accept;
	logic       m_accept;
	logic       res_valid;
	logic       push;
	frame_res_t res;
	frame_res_t out_q;
	frame_res_t skid_q;
	logic       out_v_q;
	logic       skid_v_q;

	assign s_tready = !skid_v_q;
	assign s_accept = s_tvalid && s_tready;
	assign m_accept = out_v_q && m_tready;
	assign push = res_valid;

	// frame parser
	frd_parse #(
		.MAX_DATA_BYTES(MAX_DATA_BYTES)
	) u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_accept),
		.in_byte  (s_tdata),
		.res_valid(res_valid),
		.res      (res)
	);

	// output register and skid stage occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q) begin
			out_v_q <= push;
		end else if (m_accept) begin
			if (skid_v_q) begin
				skid_v_q <= push;
			end else begin
				out_v_q <= push;
			end
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	// output register and skid stage contents
	always_ff @(posedge clk) begin
		if (!out_v_q) begin
			if (push) out_q <= res;
		end else if (m_accept) begin
			if (skid_v_q) begin
				out_q <= skid_q;
				if (push) skid_q <= res;
			end else if (push) begin
				out_q <= res;
			end
		end else if (push) begin
			skid_q <= res;
		end
	end

	// master port packing
	assign m_tvalid = out_v_q;
	assign m_tdata = TDATA_W'({out_q.data_word, out_q.data_count, out_q.command_code,
		out_q.dest_addr, out_q.source_addr});
	assign m_tuser = out_q.frame_status;

`ifndef ASSERT_OFF
	// skid stage only fills behind a full output register
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid stage holds an item while output register is empty");

	// a bad length result carries no frame contents
	a_len_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == ST_LEN) |-> (m_tdata[PackW-1:0] == '0))
		else $error("bad length result with nonzero fields");

	// draining the skid stage keeps the output valid
	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(m_accept && skid_v_q) |=> m_tvalid)
		else $error("skid item lost on drain");

	// status never takes the unused code
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == ST_OK || m_tuser == ST_CSUM || m_tuser == ST_LEN))
		else $error("unused frame status code");
`endif

endmodule

// ----- sv/frd_parse.sv -----
// ----------------------------------------------------------------------------
// frd_parse
// Byte-wise frame parser: hunts for the start byte, checks the count byte,
// collects header and data bytes and checks the trailing checksum. Gives one
// result per frame in the same cycle as the byte that ends it.
// ----------------------------------------------------------------------------
module frd_parse #(
	parameter int MAX_DATA_BYTES = frd_pkg::MAX_DATA_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [7:0]          in_byte,
	output logic                res_valid,
	output frd_pkg::frame_res_t res
);
	import frd_pkg::*;

	localparam int MaxLen = MAX_DATA_BYTES + HDR_BYTES;
	localparam int LenW = $clog2(MaxLen + 1);

	typedef enum logic [1:0] {
		PH_HUNT  = 2'd0,
		PH_COUNT = 2'd1,
		PH_BODY  = 2'd2,
		PH_CSUM  = 2'd3
	} phase_t;

	phase_t             phase_q, phase_d;
	logic [LenW-1:0]    len_q, len_d;
	logic [LenW-1:0]    seen_q, seen_d;
	logic [7:0]         sum_q, sum_d;
	logic [7:0]         src_q, src_d;
	logic [7:0]         dst_q, dst_d;
	logic [7:0]         cmd_q, cmd_d;
	logic [DATA_W-1:0]  data_q, data_d;
	logic               len_bad;
	logic [7:0]         sum_chk;

	// count byte range check
	assign len_bad = (in_byte < 8'(HDR_BYTES)) || (in_byte > 8'(MaxLen));
	// sum of everything plus checksum must wrap to zero
	assign sum_chk = sum_q + in_byte;

	// next state and result
	always_comb begin
		phase_d = phase_q;
		len_d = len_q;
		seen_d = seen_q;
		sum_d = sum_q;
		src_d = src_q;
		dst_d = dst_q;
		cmd_d = cmd_q;
		data_d = data_q;
		res_valid = 1'b0;
		res = '0;
		case (phase_q)
			PH_COUNT: begin
				if (len_bad) begin
					phase_d = PH_HUNT;
					res_valid = in_valid;
					res.frame_status = ST_LEN;
				end else begin
					phase_d = PH_BODY;
					len_d = in_byte[LenW-1:0];
					seen_d = '0;
					sum_d = in_byte;
					src_d = '0;
					dst_d = '0;
					cmd_d = '0;
					data_d = '0;
				end
			end
			PH_BODY: begin
				sum_d = sum_chk;
				if (seen_q == LenW'(0)) src_d = in_byte;
				if (seen_q == LenW'(1)) dst_d = in_byte;
				if (seen_q == LenW'(2)) cmd_d = in_byte;
				// data bytes beyond the stored slots only enter the sum
				for (int k = 0; k < DATA_SLOTS; k++) begin
					if (seen_q == LenW'(k + HDR_BYTES)) data_d[8*k +: 8] = in_byte;
				end
				seen_d = seen_q + LenW'(1);
				if (seen_d >= len_q) phase_d = PH_CSUM;
			end
			PH_CSUM: begin
				phase_d = PH_HUNT;
				res_valid = in_valid;
				res.source_addr = src_q;
				res.dest_addr = dst_q;
				res.command_code = cmd_q;
				res.data_count = CNT_W'(len_q - LenW'(HDR_BYTES));
				res.data_word = data_q;
				res.frame_status = (sum_chk == 8'd0) ? ST_OK : ST_CSUM;
			end
			default: begin
				phase_d = (in_byte == START_BYTE) ? PH_COUNT : PH_HUNT;
			end
		endcase
	end

	// parser state, advanced once per accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			len_q <= '0;
			seen_q <= '0;
		end else if (in_valid) begin
			phase_q <= phase_d;
			len_q <= len_d;
			seen_q <= seen_d;
		end
	end

	// frame contents
	always_ff @(posedge clk) begin
		if (in_valid) begin
			sum_q <= sum_d;
			src_q <= src_d;
			dst_q <= dst_d;
			cmd_q <= cmd_d;
			data_q <= data_d;
		end
	end

endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the focuser reply deframer. A byte stream of whole
// frames, corrupted checksums, bad count bytes, cut-off frames and line noise
// is pushed through the slave port. A byte-level frame decoder kept here
// predicts every record, and records taken from the master port are checked
// field by field in order. Both ports idle at random, and one long output
// hold-off fills the block so that it stalls its input.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import frd_pkg::*;

	localparam int MAX_DB = MAX_DATA_BYTES_DEF;
	localparam int RAND_BYTES = 1000;
	localparam int HOLD_AT = 300;
	localparam int HOLD_CYCLES = 200;
	localparam int BUSY_FROM = 600;
	localparam int BUSY_TO = 800;
	localparam int TAIL_CYCLES = 8;

	// decoder phases
	typedef enum logic [1:0] {
		PH_HUNT,
		PH_COUNT,
		PH_BODY,
		PH_CSUM
	} rx_phase_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [7:0]           s_tdata = '0;	// rx_byte
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	// source_addr, dest_addr, command_code, data_count, data_word, zero fill
	logic [TDATA_W-1:0]   m_tdata;
	logic [1:0]           m_tuser;	// frame_status

	// bytes still to send and records still to arrive
	logic [7:0]           rx_bytes_q [$];
	frame_res_t           frame_q [$];

	int                   bytes_taken = 0;
	int                   err_count = 0;
	int                   mismatch_count = 0;
	int                   hold_left = 0;
	bit                   hold_done = 1'b0;

	// frame decoder state
	rx_phase_t            dec_phase = PH_HUNT;
	logic [7:0]           dec_len = '0;
	logic [7:0]           dec_seen = '0;
	logic [7:0]           dec_sum = '0;
	logic [7:0]           dec_src = '0;
	logic [7:0]           dec_dst = '0;
	logic [7:0]           dec_cmd = '0;
	logic [DATA_W-1:0]    dec_data = '0;

	focuser_reply_deframer uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// random idling, switched off inside one stretch of the stream
	function automatic bit side_idles();
		if (bytes_taken >= BUSY_FROM && bytes_taken < BUSY_TO)
			return 1'b0;
		return $urandom_range(0, 99) < 23;
	endfunction

	// decode one accepted byte, queue the record it completes
	function automatic void deframe_byte(input logic [7:0] b);
		frame_res_t r;
		int idx;
		r = '0;
		case (dec_phase)
			PH_COUNT: begin
				if (int'(b) < HDR_BYTES || int'(b) - HDR_BYTES > MAX_DB) begin
					r.frame_status = ST_LEN;
					frame_q.push_back(r);
					dec_phase = PH_HUNT;
				end else begin
					dec_len = b;
					dec_seen = '0;
					dec_sum = b;
					dec_src = '0;
					dec_dst = '0;
					dec_cmd = '0;
					dec_data = '0;
					dec_phase = PH_BODY;
				end
			end
			PH_BODY: begin
				dec_sum = dec_sum + b;
				if (dec_seen == 8'd0)
					dec_src = b;
				else if (dec_seen == 8'd1)
					dec_dst = b;
				else if (dec_seen == 8'd2)
					dec_cmd = b;
				else begin
					idx = int'(dec_seen) - HDR_BYTES;
					// data bytes past the stored slots only feed the checksum
					if (idx < DATA_SLOTS)
						dec_data[8*idx +: 8] = b;
				end
				dec_seen = dec_seen + 8'd1;
				if (dec_seen >= dec_len)
					dec_phase = PH_CSUM;
			end
			PH_CSUM: begin
				r.source_addr = dec_src;
				r.dest_addr = dec_dst;
				r.command_code = dec_cmd;
				r.data_count = CNT_W'(int'(dec_len) - HDR_BYTES);
				r.data_word = dec_data;
				if (b == 8'd0 - dec_sum)
					r.frame_status = ST_OK;
				else
					r.frame_status = ST_CSUM;
				frame_q.push_back(r);
				dec_phase = PH_HUNT;
			end
			default: begin
				if (b == START_BYTE)
					dec_phase = PH_COUNT;
				else
					dec_phase = PH_HUNT;
			end
		endcase
	endfunction

	function automatic void note_mismatch(input string field, input logic [31:0] want,
			input logic [31:0] got);
		err_count++;
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $realtime, field, want, got);
	endfunction

	// queue one frame; fill < 0 gives random body bytes
	task automatic queue_frame(input int n, input int fill, input logic [7:0] corrupt);
		logic [7:0] sum;
		logic [7:0] b;
		sum = 8'(n);
		rx_bytes_q.push_back(START_BYTE);
		rx_bytes_q.push_back(8'(n));
		for (int i = 0; i < n; i++) begin
			if (fill >= 0)
				b = 8'(fill);
			else if ($urandom_range(0, 9) == 0)
				b = START_BYTE;
			else
				b = 8'($urandom_range(0, 255));
			rx_bytes_q.push_back(b);
			sum = sum + b;
		end
		rx_bytes_q.push_back((8'd0 - sum) ^ corrupt);
	endtask

	// byte driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else if (!s_tvalid || s_tready) begin
			if (rx_bytes_q.size() != 0 && !side_idles()) begin
				s_tvalid <= 1'b1;
				s_tdata <= rx_bytes_q.pop_front();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// one long output hold-off once the stream is under way
	always @(posedge clk) begin
		if (arst_n) begin
			if (!hold_done && bytes_taken >= HOLD_AT) begin
				hold_left <= HOLD_CYCLES;
				hold_done <= 1'b1;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
			end
		end
	end

	// output ready
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= !side_idles();
		end
	end

	// check records, then decode the byte taken at this edge
	always @(posedge clk) begin
		frame_res_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (frame_q.size() == 0) begin
					err_count++;
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: record 0x%0h / %0d with none pending", $realtime,
							m_tdata, m_tuser);
				end else begin
					want = frame_q.pop_front();
					if (m_tdata[7:0] !== want.source_addr)
						note_mismatch("source_addr", want.source_addr, m_tdata[7:0]);
					if (m_tdata[15:8] !== want.dest_addr)
						note_mismatch("dest_addr", want.dest_addr, m_tdata[15:8]);
					if (m_tdata[23:16] !== want.command_code)
						note_mismatch("command_code", want.command_code, m_tdata[23:16]);
					if (m_tdata[26:24] !== want.data_count)
						note_mismatch("data_count", want.data_count, m_tdata[26:24]);
					if (m_tdata[58:27] !== want.data_word)
						note_mismatch("data_word", want.data_word, m_tdata[58:27]);
					if (m_tdata[63:59] !== 5'd0)
						note_mismatch("zero fill", 0, m_tdata[63:59]);
					if (m_tuser !== want.frame_status)
						note_mismatch("frame_status", want.frame_status, m_tuser);
				end
			end
			if (s_tvalid && s_tready) begin
				deframe_byte(s_tdata);
				bytes_taken <= bytes_taken + 1;
			end
		end
	end

	// stimulus, reset and end of run
	initial begin
		int pick;
		int n;
		int cut;
		logic [7:0] flip;

		// shortest frame, checksum replaced by a start byte
		rx_bytes_q.push_back(START_BYTE);
		rx_bytes_q.push_back(8'd3);
		rx_bytes_q.push_back(8'h00);
		rx_bytes_q.push_back(8'h00);
		rx_bytes_q.push_back(8'h00);
		rx_bytes_q.push_back(START_BYTE);
		// longest frame, all ones
		queue_frame(HDR_BYTES + MAX_DB, 8'hff, 8'h00);
		// start bytes inside the body
		queue_frame(HDR_BYTES, int'(START_BYTE), 8'h00);
		// count bytes just below and above range, and a start byte as count
		rx_bytes_q.push_back(START_BYTE);
		rx_bytes_q.push_back(8'(HDR_BYTES - 1));
		rx_bytes_q.push_back(START_BYTE);
		rx_bytes_q.push_back(8'(HDR_BYTES + MAX_DB + 1));
		rx_bytes_q.push_back(START_BYTE);
		rx_bytes_q.push_back(START_BYTE);

		// random mix, mostly well-formed frames
		while (rx_bytes_q.size() < RAND_BYTES + 28) begin
			pick = $urandom_range(0, 99);
			if (pick < 72) begin
				flip = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
				queue_frame($urandom_range(HDR_BYTES, HDR_BYTES + MAX_DB), -1, flip);
			end else if (pick < 82) begin
				rx_bytes_q.push_back(START_BYTE);
				if ($urandom_range(0, 1) == 0)
					rx_bytes_q.push_back(8'($urandom_range(0, HDR_BYTES - 1)));
				else
					rx_bytes_q.push_back(8'($urandom_range(HDR_BYTES + MAX_DB + 1, 255)));
			end else if (pick < 92) begin
				// frame cut short, the next bytes run on as its body
				n = $urandom_range(HDR_BYTES, HDR_BYTES + MAX_DB);
				cut = $urandom_range(0, n);
				rx_bytes_q.push_back(START_BYTE);
				rx_bytes_q.push_back(8'(n));
				for (int i = 0; i < cut; i++)
					rx_bytes_q.push_back(8'($urandom_range(0, 255)));
			end else begin
				n = $urandom_range(1, 4);
				for (int i = 0; i < n; i++)
					rx_bytes_q.push_back(8'($urandom_range(0, 255)));
			end
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (rx_bytes_q.size() != 0 || s_tvalid)
			@(posedge clk);
		while (frame_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// run limit
	initial begin
		#2_400_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

// ----- filelist.f -----
sv/frd_pkg.sv
sv/frd_parse.sv
sv/focuser_reply_deframer.sv
verif/tb.sv
